// ----- rtl/arc_band_strip_generator_assert.svh -----
`ifndef ARC_BAND_STRIP_GENERATOR_ASSERT_SVH
`define ARC_BAND_STRIP_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ABSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("absg assertion failed");

// Next-cycle implication, checked outside reset.
`define ABSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("absg assertion failed");

`endif

// ----- rtl/absg_pkg.sv -----
package absg_pkg;

   localparam int MAX_SIDES    = 31;
   localparam int CORDIC_STEPS = 24;
   localparam int COORD_W      = 32;
   localparam int ANG_W        = 24;
   localparam int SIDE_W       = 5;
   localparam int CNT_W        = 5;
   localparam int NUM_W        = 29;
   localparam int Z_W          = 36;
   localparam int XY_W         = 34;
   localparam int TRIG_W       = 32;
   localparam int PROD_W       = 66;
   localparam int QDEPTH       = 2;

   localparam logic signed [Z_W-1:0]  Q30_PI      = 36'sd3373259426;
   localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [Z_W-1:0]  Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [XY_W-1:0] Q30_GAIN    = 34'sd652032874;
   localparam logic signed [XY_W-1:0] Q30_ONE     = 34'sd1073741824;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [COORD_W-1:0]        radius_a;
      logic [COORD_W-1:0]        radius_b;
      logic signed [ANG_W-1:0]   start_angle;
      logic signed [ANG_W-1:0]   end_angle;
      logic [SIDE_W-1:0]         reps;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert_x;
      logic signed [COORD_W-1:0] vert_y;
      logic                      last_vertex;
   } vert_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_PREP  = 7'b0000100,
      ST_ROT   = 7'b0001000,
      ST_CLAMP = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      K_START_B,
      K_START_A,
      K_MID,
      K_NEXT,
      K_END
   } kind_type;

   function automatic logic [31:0] atan_q30(input logic [CNT_W-1:0] k);
      logic [31:0] t;
      case (k)
         5'd0:  t = 32'h3243F6A8;
         5'd1:  t = 32'h1DAC6705;
         5'd2:  t = 32'h0FADBAFC;
         5'd3:  t = 32'h07F56EA6;
         5'd4:  t = 32'h03FEAB76;
         5'd5:  t = 32'h01FFD55B;
         5'd6:  t = 32'h00FFFAAA;
         5'd7:  t = 32'h007FFF55;
         5'd8:  t = 32'h003FFFEA;
         5'd9:  t = 32'h001FFFFD;
         5'd10: t = 32'h000FFFFF;
         5'd11: t = 32'h0007FFFF;
         5'd12: t = 32'h0003FFFF;
         5'd13: t = 32'h0001FFFF;
         5'd14: t = 32'h0000FFFF;
         5'd15: t = 32'h00007FFF;
         5'd16: t = 32'h00003FFF;
         5'd17: t = 32'h00001FFF;
         5'd18: t = 32'h00000FFF;
         5'd19: t = 32'h000007FF;
         5'd20: t = 32'h000003FF;
         5'd21: t = 32'h000001FF;
         5'd22: t = 32'h000000FF;
         5'd23: t = 32'h0000007F;
         5'd24: t = 32'h0000003F;
         5'd25: t = 32'h0000001F;
         5'd26: t = 32'h0000000F;
         5'd27: t = 32'h00000008;
         5'd28: t = 32'h00000004;
         5'd29: t = 32'h00000002;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage

// ----- rtl/arc_band_strip_generator.sv -----
// Triangle-strip generator for one sector of an annulus. Each request item
// yields 2*n+1 vertex items (n the side count, zero counting as one), the
// last flagged by rsp_last_vertex. A two-entry request queue decouples the
// front from a single shared rotation engine, and a two-entry result queue
// sits at the output. Each vertex passes through one step to wrap the angle,
// 24 CORDIC iterations, one clamp, four 16-bit radius partial products and
// one step to write the result, which waits while the result queue is full.
// Each step between sides adds a restoring division for the step angle, and
// a request is taken from the queue in the idle state before its first vertex.
module arc_band_strip_generator
   import absg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [COORD_W-1:0]        req_radius_a,
   input  logic [COORD_W-1:0]        req_radius_b,
   input  logic signed [ANG_W-1:0]   req_start_angle,
   input  logic signed [ANG_W-1:0]   req_end_angle,
   input  logic [SIDE_W-1:0]         req_side_count,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [COORD_W-1:0] rsp_vert_x,
   output logic signed [COORD_W-1:0] rsp_vert_y,
   output logic                      rsp_last_vertex
);

   logic     deq, q_empty, oq_push, oq_full;
   req_type  q_data;
   vert_type oq_data, head;

   absg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius_a    (req_radius_a),
      .req_radius_b    (req_radius_b),
      .req_start_angle (req_start_angle),
      .req_end_angle   (req_end_angle),
      .req_side_count  (req_side_count),
      .deq             (deq),
      .q_empty         (q_empty),
      .q_data          (q_data)
   );

   absg_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (deq),
      .oq_full (oq_full),
      .oq_push (oq_push),
      .oq_data (oq_data)
   );

   absg_out_queue u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .oq_push (oq_push),
      .oq_data (oq_data),
      .oq_full (oq_full),
      .pop     (pop),
      .empty   (empty),
      .head    (head)
   );

   assign rsp_vert_x      = head.vert_x;
   assign rsp_vert_y      = head.vert_y;
   assign rsp_last_vertex = head.last_vertex;

endmodule

// ----- rtl/absg_front.sv -----
module absg_front
   import absg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [COORD_W-1:0]        req_radius_a,
   input  logic [COORD_W-1:0]        req_radius_b,
   input  logic signed [ANG_W-1:0]   req_start_angle,
   input  logic signed [ANG_W-1:0]   req_end_angle,
   input  logic [SIDE_W-1:0]         req_side_count,
   input  logic                      deq,
   output logic                      q_empty,
   output req_type                   q_data
);

   req_type    entry_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   req_type    item;
   logic       do_push, do_pop;

   // A side count of zero behaves as one; the back end works with steps.
   always_comb begin
      logic [SIDE_W-1:0] sides;
      sides = (req_side_count == '0) ? SIDE_W'(1) : req_side_count;
      if (sides > SIDE_W'(MAX_SIDES)) begin
         sides = SIDE_W'(MAX_SIDES);
      end
      item.center_x    = req_center_x;
      item.center_y    = req_center_y;
      item.radius_a    = req_radius_a;
      item.radius_b    = req_radius_b;
      item.start_angle = req_start_angle;
      item.end_angle   = req_end_angle;
      item.reps        = sides - SIDE_W'(1);
   end

   assign full    = (count_ff == 2'(QDEPTH));
   assign q_empty = (count_ff == 2'd0);
   assign q_data  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = deq && !q_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- rtl/absg_out_queue.sv -----
module absg_out_queue
   import absg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     oq_push,
   input  vert_type oq_data,
   output logic     oq_full,
   input  logic     pop,
   output logic     empty,
   output vert_type head
);

   vert_type   entry_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign oq_full = (count_ff == 2'(QDEPTH));
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = oq_push && !oq_full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= oq_data;
      end
   end

endmodule

// ----- rtl/absg_back.sv -----
`include "arc_band_strip_generator_assert.svh"

module absg_back
   import absg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  req_type  q_data,
   output logic     q_pop,
   input  logic     oq_full,
   output logic     oq_push,
   output vert_type oq_data
);

   state_type                state_ff, state_in;
   kind_type                 kind_ff, kind_in;
   req_type                  req_ff, req_in;
   logic [SIDE_W-1:0]        step_ff, step_in;
   logic signed [ANG_W-1:0]  prev_ff, prev_in;
   logic signed [ANG_W-1:0]  next_ff, next_in;
   logic signed [ANG_W-1:0]  ang_ff, ang_in;
   logic [COORD_W-1:0]       rad_ff, rad_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [SIDE_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic                     neg_ff, neg_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [PROD_W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;

   logic signed [ANG_W:0]    delta;
   logic [ANG_W-1:0]         delta_mag;
   logic [SIDE_W-1:0]        div_step;
   logic                     load_div;
   logic [SIDE_W:0]          trial;
   logic signed [ANG_W+1:0]  next_wide;
   logic signed [ANG_W:0]    mid_sum;
   logic signed [Z_W-1:0]    z_raw, z_wrap;
   logic signed [XY_W-1:0]   dx, dy, x_neg, y_neg;
   logic signed [Z_W-1:0]    atan_ext;
   logic [16:0]              r_part;
   logic signed [TRIG_W-1:0] trig_op;
   logic signed [48:0]       prod;
   logic signed [PROD_W-1:0] term;
   logic signed [36:0]       sum_x, sum_y;
   vert_type                 vert;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [36:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 37'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -37'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] c;
      if (v > Q30_ONE) begin
         c = Q30_ONE;
      end else if (v < -Q30_ONE) begin
         c = -Q30_ONE;
      end else begin
         c = v;
      end
      return c[TRIG_W-1:0];
   endfunction

   assign delta     = {req_ff.end_angle[ANG_W-1], req_ff.end_angle}
                    - {req_ff.start_angle[ANG_W-1], req_ff.start_angle};
   assign delta_mag = delta[ANG_W] ? ANG_W'(-delta) : delta[ANG_W-1:0];

   // Restoring division: one quotient bit per cycle.
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign next_wide = {{2{req_ff.start_angle[ANG_W-1]}}, req_ff.start_angle}
                    + (delta[ANG_W] ? -$signed({1'b0, quo_ff[ANG_W:0]})
                                    :  $signed({1'b0, quo_ff[ANG_W:0]}));
   assign mid_sum   = {prev_ff[ANG_W-1], prev_ff} + {next_wide[ANG_W-1], next_wide[ANG_W-1:0]};

   // Angle to Q.30, wrapped into one turn around zero.
   assign z_raw  = {{(Z_W-ANG_W-10){ang_ff[ANG_W-1]}}, ang_ff, 10'd0};
   assign z_wrap = (z_raw > Q30_PI) ? z_raw - Q30_TWO_PI
                 : (z_raw < -Q30_PI) ? z_raw + Q30_TWO_PI : z_raw;

   assign dx       = y_ff >>> cnt_ff;
   assign dy       = x_ff >>> cnt_ff;
   assign atan_ext = $signed({{(Z_W-32){1'b0}}, atan_q30(cnt_ff)});
   assign x_neg    = neg_ff ? -x_ff : x_ff;
   assign y_neg    = neg_ff ? -y_ff : y_ff;

   // The radius is multiplied in two 16-bit halves, cosine first, then sine.
   assign r_part  = {1'b0, cnt_ff[0] ? rad_ff[31:16] : rad_ff[15:0]};
   assign trig_op = cnt_ff[1] ? sin_ff : cos_ff;
   assign prod    = $signed(r_part) * trig_op;
   assign term    = cnt_ff[0] ? (PROD_W'(prod) <<< 16) : PROD_W'(prod);

   assign sum_x = {acc_x_ff[PROD_W-1], acc_x_ff[PROD_W-1:30]}
                + {{5{req_ff.center_x[COORD_W-1]}}, req_ff.center_x};
   assign sum_y = {acc_y_ff[PROD_W-1], acc_y_ff[PROD_W-1:30]}
                + {{5{req_ff.center_y[COORD_W-1]}}, req_ff.center_y};

   assign vert.vert_x      = sat_coord(sum_x);
   assign vert.vert_y      = sat_coord(sum_y);
   assign vert.last_vertex = (kind_ff == K_END);
   assign oq_data          = vert;
   assign oq_push          = (state_ff == ST_EMIT) && !oq_full;
   assign q_pop            = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      req_in   = req_ff;
      step_in  = step_ff;
      prev_in  = prev_ff;
      next_in  = next_ff;
      ang_in   = ang_ff;
      rad_in   = rad_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      load_div = 1'b0;
      div_step = step_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               req_in   = q_data;
               ang_in   = q_data.start_angle;
               rad_in   = q_data.radius_b;
               kind_in  = K_START_B;
               step_in  = '0;
               state_in = ST_PREP;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(NUM_W)) begin
               next_in  = next_wide[ANG_W-1:0];
               ang_in   = mid_sum[ANG_W:1];
               rad_in   = req_ff.radius_b;
               kind_in  = K_MID;
               state_in = ST_PREP;
            end else begin
               num_in = {num_ff[NUM_W-2:0], 1'b0};
               if (trial >= {1'b0, req_ff.reps}) begin
                  rem_in = SIDE_W'(trial - {1'b0, req_ff.reps});
                  quo_in = {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[SIDE_W-1:0];
                  quo_in = {quo_ff[NUM_W-2:0], 1'b0};
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_PREP: begin
            if (z_wrap > Q30_HALF_PI) begin
               z_in   = z_wrap - Q30_PI;
               neg_in = 1'b1;
            end else if (z_wrap < -Q30_HALF_PI) begin
               z_in   = z_wrap + Q30_PI;
               neg_in = 1'b1;
            end else begin
               z_in   = z_wrap;
               neg_in = 1'b0;
            end
            x_in     = Q30_GAIN;
            y_in     = '0;
            cnt_in   = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_ext;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_ext;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cos_in   = clamp_trig(x_neg);
            sin_in   = clamp_trig(y_neg);
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            case (cnt_ff[1:0])
               2'd0:    acc_x_in = term;
               2'd1:    acc_x_in = acc_x_ff + term;
               2'd2:    acc_y_in = term;
               default: acc_y_in = acc_y_ff + term;
            endcase
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!oq_full) begin
               unique case (kind_ff)
                  K_START_B: begin
                     ang_in   = req_ff.start_angle;
                     rad_in   = req_ff.radius_a;
                     kind_in  = K_START_A;
                     state_in = ST_PREP;
                  end
                  K_START_A: begin
                     if (req_ff.reps == '0) begin
                        ang_in   = req_ff.end_angle;
                        rad_in   = req_ff.radius_b;
                        kind_in  = K_END;
                        state_in = ST_PREP;
                     end else begin
                        step_in  = '0;
                        prev_in  = req_ff.start_angle;
                        div_step = '0;
                        load_div = 1'b1;
                     end
                  end
                  K_MID: begin
                     ang_in   = next_ff;
                     rad_in   = req_ff.radius_a;
                     kind_in  = K_NEXT;
                     state_in = ST_PREP;
                  end
                  K_NEXT: begin
                     prev_in = next_ff;
                     step_in = step_ff + SIDE_W'(1);
                     if (step_ff + SIDE_W'(1) == req_ff.reps) begin
                        ang_in   = req_ff.end_angle;
                        rad_in   = req_ff.radius_b;
                        kind_in  = K_END;
                        state_in = ST_PREP;
                     end else begin
                        div_step = step_ff + SIDE_W'(1);
                        load_div = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_div) begin
         num_in   = NUM_W'(delta_mag) * NUM_W'(div_step + SIDE_W'(1));
         quo_in   = '0;
         rem_in   = '0;
         cnt_in   = '0;
         state_in = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= K_START_B;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      prev_ff  <= prev_in;
      next_ff  <= next_in;
      ang_ff   <= ang_in;
      rad_ff   <= rad_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      neg_ff   <= neg_in;
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
   end

   `ABSG_ASSERT_NOW(a_div_has_steps, clock, reset, state_ff == ST_DIV, req_ff.reps != '0)
   `ABSG_ASSERT_NOW(a_step_in_range, clock, reset, state_ff != ST_IDLE, step_ff <= req_ff.reps)
   `ABSG_ASSERT_NEXT(a_last_ends_item, clock, reset, oq_push && vert.last_vertex, state_ff == ST_IDLE)

endmodule

// ----- verif/arc_band_strip_generator_tb.sv -----
module arc_band_strip_generator_tb;
   import absg_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM       = 150;
   localparam int N_DIRECTED     = 14;

   typedef struct {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [COORD_W-1:0]        ra;
      logic [COORD_W-1:0]        rb;
      logic signed [ANG_W-1:0]   a0;
      logic signed [ANG_W-1:0]   a1;
      logic [SIDE_W-1:0]         sides;
      logic                      typed;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
   } arc_row_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic [COORD_W-1:0]        req_radius_a = '0;
   logic [COORD_W-1:0]        req_radius_b = '0;
   logic signed [ANG_W-1:0]   req_start_angle = '0;
   logic signed [ANG_W-1:0]   req_end_angle = '0;
   logic [SIDE_W-1:0]         req_side_count = '0;
   logic signed [COORD_W-1:0] rsp_vert_x, rsp_vert_y;
   logic                      rsp_last_vertex;

   vertex_type  strip_expected[$];
   arc_row_type arc_rows[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   arc_band_strip_generator uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_radius_a(req_radius_a), .req_radius_b(req_radius_b),
      .req_start_angle(req_start_angle), .req_end_angle(req_end_angle),
      .req_side_count(req_side_count), .empty(empty), .pop(pop),
      .rsp_vert_x(rsp_vert_x), .rsp_vert_y(rsp_vert_y),
      .rsp_last_vertex(rsp_last_vertex)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Cosine and sine of a Q3.20 angle, both in Q.30, by the fixed-gain CORDIC.
   function automatic void cordic_trig(input longint angle, output longint c,
                                       output longint s);
      longint z, x, y, dx, dy;
      bit     fold;
      z = angle * 1024;
      x = Q30_GAIN;
      y = 0;
      fold = 1'b0;
      if (z > Q30_PI) z -= Q30_TWO_PI;
      else if (z < -Q30_PI) z += Q30_TWO_PI;
      if (z > Q30_HALF_PI) begin
         z -= Q30_PI;
         fold = 1'b1;
      end else if (z < -Q30_HALF_PI) begin
         z += Q30_PI;
         fold = 1'b1;
      end
      for (int k = 0; k < CORDIC_STEPS && k < 30; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(k));
         end else begin
            x += dx; y -= dy; z += longint'(atan_q30(k));
         end
      end
      if (fold) begin
         x = -x;
         y = -y;
      end
      c = (x < -Q30_ONE) ? -Q30_ONE : (x > Q30_ONE) ? Q30_ONE : x;
      s = (y < -Q30_ONE) ? -Q30_ONE : (y > Q30_ONE) ? Q30_ONE : y;
   endfunction

   function automatic logic signed [31:0] sat_coord(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic vertex_type arc_vertex(longint cx, longint cy, longint r,
                                             longint angle, bit last);
      longint     c, s;
      vertex_type v;
      cordic_trig(angle, c, s);
      v.x = sat_coord(cx + ((r * c) >>> 30));
      v.y = sat_coord(cy + ((r * s) >>> 30));
      v.last = last;
      return v;
   endfunction

   task automatic predict_strip(input arc_row_type row);
      longint cx, cy, ra, rb, a0, a1, n, reps, d, prev, next, mid;
      cx = row.cx; cy = row.cy;
      ra = row.ra; rb = row.rb;
      a0 = row.a0; a1 = row.a1;
      n = row.sides;
      if (n < 1) n = 1;
      if (n > MAX_SIDES) n = MAX_SIDES;
      reps = n - 1;
      d = a1 - a0;
      strip_expected.push_back(arc_vertex(cx, cy, rb, a0, 1'b0));
      strip_expected.push_back(arc_vertex(cx, cy, ra, a0, 1'b0));
      prev = a0;
      for (longint i = 0; i < reps; i++) begin
         // SystemVerilog division truncates toward zero, matching the block.
         next = a0 + (d * (i + 1)) / reps;
         mid = (prev + next) >>> 1;
         strip_expected.push_back(arc_vertex(cx, cy, rb, mid, 1'b0));
         strip_expected.push_back(arc_vertex(cx, cy, ra, next, 1'b0));
         prev = next;
      end
      strip_expected.push_back(arc_vertex(cx, cy, rb, a1, 1'b1));
   endtask

   function automatic arc_row_type make_row(longint cx, longint cy, longint ra,
                                            longint rb, longint a0, longint a1,
                                            int sides);
      arc_row_type r;
      r.cx = cx; r.cy = cy; r.ra = ra; r.rb = rb;
      r.a0 = a0; r.a1 = a1; r.sides = sides;
      r.typed = 1'b0; r.first_x = '0; r.first_y = '0;
      return r;
   endfunction

   function automatic arc_row_type random_row();
      arc_row_type r;
      r = make_row(0, 0, 0, 0, 0, 0, 0);
      r.cx = $urandom();
      r.cy = $urandom();
      r.ra = $urandom();
      r.rb = $urandom();
      if ($urandom_range(3) != 0) begin
         // Mostly sensible geometry so that few sums saturate.
         r.cx = $signed(r.cx) >>> $urandom_range(12);
         r.cy = $signed(r.cy) >>> $urandom_range(12);
         r.ra = r.ra >> $urandom_range(14);
         r.rb = r.rb >> $urandom_range(14);
      end
      r.a0 = $urandom();
      r.a1 = $urandom();
      // Small side counts dominate; the largest appears now and then.
      r.sides = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(6);
      return r;
   endfunction

   task automatic send_item(input arc_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_center_x <= row.cx;
      req_center_y <= row.cy;
      req_radius_a <= row.ra;
      req_radius_b <= row.rb;
      req_start_angle <= row.a0;
      req_end_angle <= row.a1;
      req_side_count <= row.sides;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (strip_expected.size() != 0) @(posedge clock);
   endtask

   // Accepted requests feed the predictor; the typed-in first vertex is
   // checked against it as well.
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         arc_row_type row;
         int          base;
         row = arc_rows.pop_front();
         base = strip_expected.size();
         predict_strip(row);
         if (row.typed && (strip_expected[base].x !== row.first_x ||
                           strip_expected[base].y !== row.first_y)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row: expected first vertex %h %h, predicted %h %h",
                        row.first_x, row.first_y, strip_expected[base].x,
                        strip_expected[base].y);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (!empty && pop) begin
            vertex_type want;
            if (strip_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected vertex item %h %h %b",
                           rsp_vert_x, rsp_vert_y, rsp_last_vertex);
            end else begin
               want = strip_expected.pop_front();
               if (rsp_vert_x !== want.x || rsp_vert_y !== want.y ||
                   rsp_last_vertex !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("vertex mismatch: expected %h %h %b, got %h %h %b",
                              want.x, want.y, want.last,
                              rsp_vert_x, rsp_vert_y, rsp_last_vertex);
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      arc_row_type directed[N_DIRECTED];
      arc_row_type row;
      int          tail;
      // With both radii zero every vertex sits exactly on the centre.
      directed[0] = make_row(32'sh0001_0000, -32'sh0002_0000, 0, 0, 0, 0, 1);
      directed[0].typed = 1'b1;
      directed[0].first_x = 32'sh0001_0000;
      directed[0].first_y = -32'sh0002_0000;
      // A full radius at an eighth turn from the axis pushes both coordinates
      // of the first vertex far past the top of the range.
      directed[1] = make_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 24'sh0C90FE, 0, 0);
      directed[1].typed = 1'b1;
      directed[1].first_x = 32'sh7FFF_FFFF;
      directed[1].first_y = 32'sh7FFF_FFFF;
      directed[2] = make_row(-64'sd2147483648, -64'sd2147483648, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 24'sh7FFFFF, 24'sh800000, 31);
      directed[3] = make_row(0, 0, 0, 0, 0, 0, 0);
      directed[3].typed = 1'b1;
      directed[3].first_x = 32'sh0;
      directed[3].first_y = 32'sh0;
      directed[4] = make_row(32'sh0010_0000, -32'sh0010_0000, 32'h0005_0000,
                             32'h0008_0000, 24'sh800000, 24'sh7FFFFF, 2);
      directed[5] = make_row(0, 0, 32'h0001_0000, 32'h0003_0000, 24'sh7FFFFF, 0, 7);
      directed[6] = make_row(0, 0, 32'h0001_0000, 32'h0003_0000, 24'sh1921FB,
                             -24'sh1921FB, 5);
      directed[7] = make_row(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 0,
                             24'sh3243F6, -24'sh3243F6, 3);
      directed[8] = make_row(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h8000_0000,
                             24'sh0C90FD, 24'sh0C90FE, 31);
      directed[9] = make_row(0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 24'shAAAAAA,
                             24'sh555555, 21);
      directed[10] = make_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'hAAAA_AAAA, 24'sh555555, 24'shAAAAAA, 10);
      directed[11] = make_row(0, 0, 32'h0002_0000, 32'h0002_0000, 24'sh000001,
                              24'sh000000, 16);
      directed[12] = make_row(-32'sh0001_0000, 32'sh0001_0000, 32'h0001_8000,
                              32'h0000_8000, -24'sh25B2F9, 24'sh25B2F9, 4);
      directed[13] = make_row(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'sh3FFFFF,
                              -24'sh400000, 8);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         arc_rows.push_back(directed[i]);
         send_item(directed[i]);
      end
      push <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            row = random_row();
            arc_rows.push_back(row);
            send_item(row);
         end
      end
      push <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      tail = 0;
      while (tail < 200) begin
         @(posedge clock);
         tail++;
      end
      if (mismatches == 0 && strip_expected.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
